>>> rtl/assert_macros.svh
// Assertion macros of the first-free room allocator RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold on every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed in first-free room allocator");
// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition in first-free room allocator");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/ffra_pkg.sv
// Shared types and constants of the first-free room allocator.
// Used by the slot memory, the sweep engine and the top level; depends on nothing.
package ffra_pkg;

   localparam int SlotsDefault = 64;
   localparam int TimeW        = 32;
   localparam int RoomW        = 6;
   localparam int CountW       = 7;

   localparam logic [CountW-1:0] CountMax   = 7'd127;
   localparam logic [CountW-1:0] LimitReset = 7'd64;

   typedef logic [TimeW-1:0] time_type;

   // One memory word: the slot's used mark and its remaining occupied time.
   typedef struct packed {
      logic     touched;
      time_type remaining;
   } slot_word_type;

   // A request handed from the top level to the sweep engine.
   typedef struct packed {
      logic     new_run;
      time_type arrival_time;
      time_type stay_length;
   } job_type;

   // What the sweep engine reports once a pass has finished.
   typedef struct packed {
      logic [RoomW-1:0]  room;
      logic [CountW-1:0] rooms_used;
      logic              all_busy;
   } result_type;

endpackage

>>> rtl/ffra_slot_mem.sv
// Slot memory of the first-free room allocator: one word per slot.
// One write port and one read port with registered read data; uses ffra_pkg.
module ffra_slot_mem #(
   parameter int SLOTS = ffra_pkg::SlotsDefault,
   parameter int AW    = $clog2(SLOTS)
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output ffra_pkg::slot_word_type rd_data,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  ffra_pkg::slot_word_type wr_data
);

   ffra_pkg::slot_word_type slot_ram_ff [SLOTS];
   ffra_pkg::slot_word_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ram_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ffra_sweep.sv
// Sweep engine: ages every slot, picks the first free one and keeps the run count.
// Instantiates ffra_slot_mem; uses ffra_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffra_sweep #(
   parameter int SLOTS = ffra_pkg::SlotsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ffra_pkg::job_type    job,
   output logic                 busy,
   output logic                 done,
   output ffra_pkg::result_type result
);

   localparam int AW = $clog2(SLOTS);
   localparam int IW = (AW > ffra_pkg::RoomW) ? AW : ffra_pkg::RoomW;
   localparam logic [AW-1:0] IdxLast = AW'(SLOTS - 1);

   // Pass control.
   logic                          rd_act_ff, rd_act_in;
   logic [AW-1:0]                 rd_idx_ff, rd_idx_in;
   logic                          p_valid_ff, p_valid_in;
   logic [AW-1:0]                 p_idx_ff, p_idx_in;
   logic                          done_ff, done_in;
   // Per-request operands.
   ffra_pkg::time_type            gap_ff, gap_in;
   ffra_pkg::time_type            stay_ff, stay_in;
   logic                          clear_ff, clear_in;
   // Run state outside the memory.
   logic                          mem_clean_ff, mem_clean_in;
   ffra_pkg::time_type            prev_arrival_ff, prev_arrival_in;
   logic [ffra_pkg::CountW-1:0]   count_ff, count_in;
   logic                          found_ff, found_in;
   logic [AW-1:0]                 found_idx_ff, found_idx_in;

   // Memory ports and datapath.
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   ffra_pkg::slot_word_type       rd_data;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   ffra_pkg::slot_word_type       wr_data;
   ffra_pkg::slot_word_type       cur_word;
   ffra_pkg::time_type            aged;
   logic                          take;
   logic [IW-1:0]                 slot_wide;

   ffra_slot_mem #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_slot_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Reads walk the slots in order; the write-back trails by one slot.
   assign rd_en   = rd_act_ff;
   assign rd_addr = rd_idx_ff;

   // A cleared run, or a memory never written since reset, reads as all zero.
   assign cur_word = clear_ff ? '0 : rd_data;
   assign aged     = (cur_word.remaining > gap_ff) ? cur_word.remaining - gap_ff : '0;
   assign take     = p_valid_ff && !found_ff && (aged == '0);

   assign wr_en   = p_valid_ff;
   assign wr_addr = p_idx_ff;
   always_comb begin
      if (take) begin
         wr_data.touched   = 1'b1;
         wr_data.remaining = stay_ff;
      end else begin
         wr_data.touched   = cur_word.touched;
         wr_data.remaining = aged;
      end
   end

   // Next-state logic of the pass and the run state.
   always_comb begin
      rd_act_in       = rd_act_ff;
      rd_idx_in       = rd_idx_ff;
      p_valid_in      = rd_act_ff;
      p_idx_in        = rd_idx_ff;
      done_in         = p_valid_ff && (p_idx_ff == IdxLast);
      gap_in          = gap_ff;
      stay_in         = stay_ff;
      clear_in        = clear_ff;
      mem_clean_in    = mem_clean_ff;
      prev_arrival_in = prev_arrival_ff;
      count_in        = count_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;

      if (start) begin
         rd_act_in       = 1'b1;
         rd_idx_in       = '0;
         stay_in         = job.stay_length;
         clear_in        = job.new_run || mem_clean_ff;
         prev_arrival_in = job.arrival_time;
         found_in        = 1'b0;
         found_idx_in    = '0;
         if (job.new_run) begin
            gap_in   = '0;
            count_in = '0;
         end else if (job.arrival_time > prev_arrival_ff) begin
            gap_in = job.arrival_time - prev_arrival_ff;
         end else begin
            gap_in = '0;
         end
      end

      // Read side steps through the slots and stops after the last one.
      if (rd_act_ff) begin
         if (rd_idx_ff == IdxLast) begin
            rd_act_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end

      // The first free slot takes the request; a fresh slot raises the count.
      if (take) begin
         found_in     = 1'b1;
         found_idx_in = p_idx_ff;
         if (!cur_word.touched && (count_ff != ffra_pkg::CountMax)) begin
            count_in = count_ff + 1'b1;
         end
      end

      // After one full pass every slot holds written data.
      if (done_in) begin
         mem_clean_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_act_ff       <= 1'b0;
         p_valid_ff      <= 1'b0;
         done_ff         <= 1'b0;
         mem_clean_ff    <= 1'b1;
         prev_arrival_ff <= '0;
         count_ff        <= '0;
         found_ff        <= 1'b0;
      end else begin
         rd_act_ff       <= rd_act_in;
         p_valid_ff      <= p_valid_in;
         done_ff         <= done_in;
         mem_clean_ff    <= mem_clean_in;
         prev_arrival_ff <= prev_arrival_in;
         count_ff        <= count_in;
         found_ff        <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      p_idx_ff     <= p_idx_in;
      gap_ff       <= gap_in;
      stay_ff      <= stay_in;
      clear_ff     <= clear_in;
      found_idx_ff <= found_idx_in;
   end

   // Result of the finished pass; it holds until the next start.
   assign slot_wide         = found_ff ? IW'(found_idx_ff) : '0;
   assign result.room       = slot_wide[ffra_pkg::RoomW-1:0];
   assign result.rooms_used = count_ff;
   assign result.all_busy   = !found_ff;

   assign busy = rd_act_ff || p_valid_ff;
   assign done = done_ff;

   // Checks on the sweep.
   `ASSERT_AT(a_start_when_idle, clock, reset, start |-> !(rd_act_ff || p_valid_ff || done_ff))
   `ASSERT_AT(a_pass_ends, clock, reset, done_in |=> (!p_valid_ff && done_ff))
   `ASSERT_AT(a_count_no_drop, clock, reset, !start |=> (count_ff >= $past(count_ff)))
   `ASSERT_NEVER(a_no_same_slot, clock, reset, wr_en && rd_en && (wr_addr == rd_addr))

endmodule

>>> rtl/first_free_room_allocator.sv
// Top level of the first-free room allocator: handshakes, limit register, result register.
// Instantiates ffra_sweep; uses ffra_pkg.
//
//   channel   ports                                        direction
//   request   req_valid, req_stall, req_new_run,          in
//             req_arrival_time, req_stay_length
//   response  rsp_valid, rsp_stall, rsp_room,              out
//             rsp_rooms_used, rsp_over_limit, rsp_all_busy
//   config    csr_wr_en, csr_wr_data (room limit)          in
//
// A request is swept with one read-modify-write of the slot memory per slot, in slot order;
// the next request is accepted once its response has moved into the output register.
// Reset is synchronous and active high; the memory is not cleared, it reads as zero
// until its first full pass. The room limit resets to 64.
// A new request is accepted while an earlier response still waits in the output
// register; a finished sweep waits for that register to free before it loads it.
module first_free_room_allocator #(
   parameter int SLOTS = ffra_pkg::SlotsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_new_run,
   input  logic [ffra_pkg::TimeW-1:0]        req_arrival_time,
   input  logic [ffra_pkg::TimeW-1:0]        req_stay_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ffra_pkg::RoomW-1:0]        rsp_room,
   output logic [ffra_pkg::CountW-1:0]       rsp_rooms_used,
   output logic                              rsp_over_limit,
   output logic                              rsp_all_busy,
   input  logic                              csr_wr_en,
   input  logic [ffra_pkg::CountW-1:0]       csr_wr_data
);

   logic                          start;
   ffra_pkg::job_type             job;
   logic                          sweep_busy;
   logic                          sweep_done;
   ffra_pkg::result_type          result;
   logic                          out_free;
   logic                          load;

   logic                          hold_ff, hold_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ffra_pkg::CountW-1:0]   room_limit_ff;
   logic [ffra_pkg::RoomW-1:0]    rsp_room_ff;
   logic [ffra_pkg::CountW-1:0]   rsp_rooms_used_ff;
   logic                          rsp_over_limit_ff;
   logic                          rsp_all_busy_ff;

   // Request side: stalled while a sweep runs or its response is pending.
   assign req_stall = sweep_busy || sweep_done || hold_ff;
   assign start     = req_valid && !req_stall;

   assign job.new_run      = req_new_run;
   assign job.arrival_time = req_arrival_time;
   assign job.stay_length  = req_stay_length;

   ffra_sweep #(
      .SLOTS (SLOTS)
   ) u_sweep (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .job    (job),
      .busy   (sweep_busy),
      .done   (sweep_done),
      .result (result)
   );

   // Output register loads when it is empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (sweep_done || hold_ff) && out_free;

   always_comb begin
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         hold_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end else begin
         if (sweep_done) begin
            hold_in = 1'b1;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // Control registers and the room limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         room_limit_ff <= ffra_pkg::LimitReset;
      end else begin
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            room_limit_ff <= csr_wr_data;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_room_ff       <= result.room;
         rsp_rooms_used_ff <= result.rooms_used;
         rsp_over_limit_ff <= result.rooms_used > room_limit_ff;
         rsp_all_busy_ff   <= result.all_busy;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_room       = rsp_room_ff;
   assign rsp_rooms_used = rsp_rooms_used_ff;
   assign rsp_over_limit = rsp_over_limit_ff;
   assign rsp_all_busy   = rsp_all_busy_ff;

endmodule
